/* rtl/rgc_pkg.sv */
// ----------------------------------------------------------------------------
// rgc_pkg
// Shared types, constants and tables of the grid ray-cast column engine.
// ----------------------------------------------------------------------------
package rgc_pkg;

  // default sizes of the map and the march
  localparam int MAP_DIM_DEF   = 64;
  localparam int CELL_SIZE_DEF = 40;
  localparam int MAX_STEPS_DEF = 1024;

  // field widths
  localparam int POS_W     = 20;
  localparam int HGT_W     = 12;
  localparam int FOCAL_W   = 12;
  localparam int WHE_W     = 8;
  localparam int CFG_W     = 12;
  localparam int OP_W      = 2;
  localparam int ANGLE_W   = 16;
  localparam int STEP_W    = 7;
  localparam int COLOFF_W  = 11;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 80;

  // cordic unit
  localparam int CORDIC_ITERS = 14;
  localparam int ITER_W       = 4;
  localparam int XY_W         = 24;
  localparam int Z_W          = 18;
  localparam int CS_W         = 18;
  localparam logic signed [XY_W-1:0] CORDIC_START = 24'sd9949;
  localparam logic [ANGLE_W-1:0] ANG_QUARTER = 16'd16384;
  localparam logic [ANGLE_W-1:0] ANG_HALF    = 16'd32768;
  localparam logic [ANGLE_W-1:0] ANG_3QUART  = 16'd49152;

  // ray positions are Q.14, player positions Q.8
  localparam int RAY_W    = 40;
  localparam int FRAC_SH  = 14;
  localparam int POS_SH   = 6;
  localparam int RECIP_SH = 24;
  localparam int NUM_W    = 28;

  localparam logic [POS_W-1:0] POS_MAX    = 20'hFFFFF;
  localparam logic [HGT_W-1:0] HEIGHT_MAX = 12'hFFF;

  typedef enum logic [OP_W-1:0] {
    OP_MAP_WRITE = 2'd0,
    OP_MOVE      = 2'd1,
    OP_CAST      = 2'd2,
    OP_NOP       = 2'd3
  } op_e;

  typedef enum logic {
    CFG_FOCAL     = 1'b0,
    CFG_WALL_HALF = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ANG_HEADING = 2'd0,
    ANG_RAY     = 2'd1,
    ANG_COLUMN  = 2'd2
  } ang_src_e;

  typedef enum logic [1:0] {
    SAVE_NONE = 2'd0,
    SAVE_ANG  = 2'd1,
    SAVE_CS   = 2'd2,
    SAVE_CC   = 2'd3
  } cor_save_e;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      map_wr;
    logic      cor_init;
    logic      cor_vec;
    ang_src_e  cor_src;
    logic      cor_step;
    cor_save_e cor_save;
    logic      mv_target;
    logic      mv_commit;
    logic      ray_init;
    logic      probe_cell;
    logic      probe_read;
    logic      step_fwd;
    logic      step_back;
    logic      perp_mul;
    logic      perp_sat;
    logic      h_max;
    logic      div_init;
    logic      div_step;
    logic      h_sat;
    logic      emit;
  } rgc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cor_done;
    logic blocked;
    logic n_max;
    logic perp_zero;
    logic div_done;
    logic out_free;
  } rgc_sts_t;

  // arctangent of 2^-i in binary angle units
  function automatic logic signed [Z_W-1:0] atan_step(input logic [ITER_W-1:0] i);
    logic signed [Z_W-1:0] r;
    unique case (i)
      4'd0:    r = 18'sd8192;
      4'd1:    r = 18'sd4836;
      4'd2:    r = 18'sd2555;
      4'd3:    r = 18'sd1297;
      4'd4:    r = 18'sd651;
      4'd5:    r = 18'sd326;
      4'd6:    r = 18'sd163;
      4'd7:    r = 18'sd81;
      4'd8:    r = 18'sd41;
      4'd9:    r = 18'sd20;
      4'd10:   r = 18'sd10;
      4'd11:   r = 18'sd5;
      4'd12:   r = 18'sd3;
      4'd13:   r = 18'sd1;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/rgc_ctrl.sv */
// ----------------------------------------------------------------------------
// rgc_ctrl
// Sequencer: map write, move and cast each run as a series of datapath steps.
// ----------------------------------------------------------------------------
module rgc_ctrl
  import rgc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] in_op_i,
  output logic            in_ready_o,
  input  rgc_sts_t        sts_i,
  output rgc_cmd_t        cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_WRITE, S_FIN,
    S_MV_INIT, S_MV_ROT, S_MV_TGT,
    S_CA_VINIT, S_CA_VEC, S_CA_R1INIT, S_CA_R1, S_CA_R2INIT, S_CA_R2, S_CA_START,
    S_P_CELL, S_P_READ, S_P_TEST,
    S_CA_PMUL, S_CA_PSAT, S_CA_CHK, S_CA_DIV, S_CA_HSAT
  } state_e;

  state_e state_q, state_d;
  logic   is_move_q, is_move_d;
  logic   fwd_q, fwd_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d   = state_q;
    is_move_d = is_move_q;
    fwd_d     = fwd_q;
    cmd_o     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (op_e'(in_op_i))
            OP_MAP_WRITE: state_d = S_WRITE;
            OP_MOVE: begin
              state_d   = S_MV_INIT;
              is_move_d = 1'b1;
            end
            OP_CAST: begin
              state_d   = S_CA_VINIT;
              is_move_d = 1'b0;
            end
            OP_NOP:  state_d = S_FIN;
          endcase
        end
      end
      S_WRITE: begin
        cmd_o.map_wr = 1'b1;
        state_d      = S_FIN;
      end
      S_MV_INIT: begin
        cmd_o.cor_init = 1'b1;
        cmd_o.cor_src  = ANG_HEADING;
        state_d        = S_MV_ROT;
      end
      S_MV_ROT: begin
        if (sts_i.cor_done) begin
          cmd_o.cor_save = SAVE_CS;
          state_d        = S_MV_TGT;
        end else begin
          cmd_o.cor_step = 1'b1;
        end
      end
      S_MV_TGT: begin
        cmd_o.mv_target = 1'b1;
        state_d         = S_P_CELL;
      end
      S_CA_VINIT: begin
        cmd_o.cor_init = 1'b1;
        cmd_o.cor_vec  = 1'b1;
        state_d        = S_CA_VEC;
      end
      S_CA_VEC: begin
        if (sts_i.cor_done) begin
          cmd_o.cor_save = SAVE_ANG;
          state_d        = S_CA_R1INIT;
        end else begin
          cmd_o.cor_step = 1'b1;
        end
      end
      S_CA_R1INIT: begin
        cmd_o.cor_init = 1'b1;
        cmd_o.cor_src  = ANG_RAY;
        state_d        = S_CA_R1;
      end
      S_CA_R1: begin
        if (sts_i.cor_done) begin
          cmd_o.cor_save = SAVE_CS;
          state_d        = S_CA_R2INIT;
        end else begin
          cmd_o.cor_step = 1'b1;
        end
      end
      S_CA_R2INIT: begin
        cmd_o.cor_init = 1'b1;
        cmd_o.cor_src  = ANG_COLUMN;
        state_d        = S_CA_R2;
      end
      S_CA_R2: begin
        if (sts_i.cor_done) begin
          cmd_o.cor_save = SAVE_CC;
          state_d        = S_CA_START;
        end else begin
          cmd_o.cor_step = 1'b1;
        end
      end
      S_CA_START: begin
        cmd_o.ray_init = 1'b1;
        fwd_d          = 1'b1;
        state_d        = S_P_CELL;
      end
      S_P_CELL: begin
        cmd_o.probe_cell = 1'b1;
        state_d          = S_P_READ;
      end
      S_P_READ: begin
        cmd_o.probe_read = 1'b1;
        state_d          = S_P_TEST;
      end
      S_P_TEST: begin
        // march decision on the probed cell
        if (is_move_q) begin
          cmd_o.mv_commit = 1'b1;
          state_d         = S_FIN;
        end else if (fwd_q && !sts_i.blocked) begin
          if (sts_i.n_max) begin
            state_d = S_FIN;
          end else begin
            cmd_o.step_fwd = 1'b1;
            state_d        = S_P_CELL;
          end
        end else if (sts_i.blocked) begin
          fwd_d = 1'b0;
          if (sts_i.n_max) begin
            state_d = S_FIN;
          end else begin
            cmd_o.step_back = 1'b1;
            state_d         = S_P_CELL;
          end
        end else begin
          state_d = S_CA_PMUL;
        end
      end
      S_CA_PMUL: begin
        cmd_o.perp_mul = 1'b1;
        state_d        = S_CA_PSAT;
      end
      S_CA_PSAT: begin
        cmd_o.perp_sat = 1'b1;
        state_d        = S_CA_CHK;
      end
      S_CA_CHK: begin
        if (sts_i.perp_zero) begin
          cmd_o.h_max = 1'b1;
          state_d     = S_FIN;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = S_CA_DIV;
        end
      end
      S_CA_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_CA_HSAT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_CA_HSAT: begin
        cmd_o.h_sat = 1'b1;
        state_d     = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      is_move_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      is_move_q <= is_move_d;
      fwd_q     <= fwd_d;
    end
  end

endmodule

/* rtl/rgc_dp.sv */
// ----------------------------------------------------------------------------
// rgc_dp
// Datapath: wall map, player position, shared cordic unit, ray marcher,
// perpendicular distance and a bit-serial divider for the wall height.
// ----------------------------------------------------------------------------
module rgc_dp
  import rgc_pkg::*;
#(
  parameter int MAP_DIM         = MAP_DIM_DEF,
  parameter int CELL_SIZE       = CELL_SIZE_DEF,
  parameter int MAX_MARCH_STEPS = MAX_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  rgc_cmd_t              cmd_i,
  output rgc_sts_t              sts_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  localparam int IDX_W     = $clog2(MAP_DIM);
  localparam int ADDR_W    = $clog2(MAP_DIM * MAP_DIM);
  localparam int LIMIT     = MAP_DIM * CELL_SIZE;
  localparam int PIX_W     = $clog2(LIMIT);
  localparam int RECIP     = ((1 << RECIP_SH) + CELL_SIZE - 1) / CELL_SIZE;
  localparam int RECIP_W   = RECIP_SH + 1;
  localparam int PRODC_W   = PIX_W + RECIP_W;
  localparam int RPIX_W    = RAY_W - FRAC_SH;
  localparam int N_W       = $clog2(MAX_MARCH_STEPS + 1);
  localparam int T_W       = $clog2(5 * MAX_MARCH_STEPS + 1) + 1;
  localparam int PROD_W    = T_W - 1 + CS_W - 1;
  localparam int DIVC_W    = $clog2(NUM_W + 1);
  localparam int TGT_W     = POS_W + 2;
  localparam int MV_W      = STEP_W + CS_W + 1;

  // configuration registers
  logic [FOCAL_W-1:0] focal_q;
  logic [WHE_W-1:0]   whe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q <= 12'd400;
      whe_q   <= 8'd20;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FOCAL:     focal_q <= cfg_wdata_i[FOCAL_W-1:0];
        CFG_WALL_HALF: whe_q   <= cfg_wdata_i[WHE_W-1:0];
      endcase
    end
  end

  // item fields
  logic [5:0]                 row_q, col_q;
  logic                       wall_q;
  logic [ANGLE_W-1:0]         heading_q;
  logic signed [STEP_W-1:0]   step_q;
  logic signed [COLOFF_W-1:0] coloff_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_q     <= in_data_i[5:0];
      col_q     <= in_data_i[11:6];
      wall_q    <= in_data_i[12];
      heading_q <= in_data_i[28:13];
      step_q    <= in_data_i[35:29];
      coloff_q  <= in_data_i[46:36];
    end
  end

  // wall map
  logic                  map_mem [MAP_DIM * MAP_DIM];
  logic [IDX_W-1:0]      cx_q, cy_q;
  logic                  oob_q, rd_q;
  logic                  row_ok, col_ok;
  logic [ADDR_W-1:0]     wr_addr, rd_addr;

  assign row_ok  = (32'(row_q) < 32'(MAP_DIM));
  assign col_ok  = (32'(col_q) < 32'(MAP_DIM));
  assign wr_addr = ADDR_W'(32'(row_q) * MAP_DIM + 32'(col_q));
  assign rd_addr = ADDR_W'(32'(cy_q) * MAP_DIM + 32'(cx_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.map_wr && row_ok && col_ok) begin
      map_mem[wr_addr] <= wall_q;
    end
    if (cmd_i.probe_read) begin
      rd_q <= map_mem[rd_addr];
    end
  end

  // cordic unit, rotation or vectoring, one iteration a cycle
  logic signed [XY_W-1:0] cor_x_q, cor_y_q, shx, shy;
  logic signed [Z_W-1:0]  cor_z_q, st;
  logic [ITER_W-1:0]      cor_i_q;
  logic                   cor_vec_q, cor_flip_q;
  logic [ANGLE_W-1:0]     ang_in, ang_rot;
  logic                   flip_in;
  logic signed [Z_W-1:0]  ang_q;
  logic signed [CS_W-1:0] cos_q, sin_q, cc_q, cv, sv;

  always_comb begin
    unique case (cmd_i.cor_src)
      ANG_HEADING: ang_in = heading_q;
      ANG_RAY:     ang_in = heading_q + ang_q[ANGLE_W-1:0];
      ANG_COLUMN:  ang_in = ang_q[ANGLE_W-1:0];
      default:     ang_in = heading_q;
    endcase
    flip_in = (ang_in >= ANG_QUARTER) && (ang_in < ANG_3QUART);
    ang_rot = flip_in ? ang_in + ANG_HALF : ang_in;
  end

  assign shx = cor_y_q >>> cor_i_q;
  assign shy = cor_x_q >>> cor_i_q;
  assign st  = atan_step(cor_i_q);
  assign cv  = cor_flip_q ? CS_W'(-cor_x_q) : CS_W'(cor_x_q);
  assign sv  = cor_flip_q ? CS_W'(-cor_y_q) : CS_W'(cor_y_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cor_init) begin
      cor_i_q   <= '0;
      cor_vec_q <= cmd_i.cor_vec;
      if (cmd_i.cor_vec) begin
        cor_x_q    <= signed'({{(XY_W-FOCAL_W-8){1'b0}}, focal_q, 8'b0});
        cor_y_q    <= {{(XY_W-COLOFF_W-8){coloff_q[COLOFF_W-1]}}, coloff_q, 8'b0};
        cor_z_q    <= '0;
        cor_flip_q <= 1'b0;
      end else begin
        cor_x_q    <= CORDIC_START;
        cor_y_q    <= '0;
        cor_z_q    <= {{(Z_W-ANGLE_W){ang_rot[ANGLE_W-1]}}, ang_rot};
        cor_flip_q <= flip_in;
      end
    end else if (cmd_i.cor_step) begin
      cor_i_q <= cor_i_q + 1'b1;
      if (cor_vec_q) begin
        if (cor_y_q != '0) begin
          if (!cor_y_q[XY_W-1]) begin
            cor_x_q <= cor_x_q + shx;
            cor_y_q <= cor_y_q - shy;
            cor_z_q <= cor_z_q + st;
          end else begin
            cor_x_q <= cor_x_q - shx;
            cor_y_q <= cor_y_q + shy;
            cor_z_q <= cor_z_q - st;
          end
        end
      end else if (!cor_z_q[Z_W-1]) begin
        cor_x_q <= cor_x_q - shx;
        cor_y_q <= cor_y_q + shy;
        cor_z_q <= cor_z_q - st;
      end else begin
        cor_x_q <= cor_x_q + shx;
        cor_y_q <= cor_y_q - shy;
        cor_z_q <= cor_z_q + st;
      end
    end
  end

  // results of the cordic runs
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.cor_save)
      SAVE_ANG: ang_q <= cor_z_q;
      SAVE_CS: begin
        cos_q <= cv;
        sin_q <= sv;
      end
      SAVE_CC:  cc_q <= cv[CS_W-1] ? '0 : cv;
      default: ;
    endcase
  end

  // player position and move target
  logic [POS_W-1:0]        px_q, py_q;
  logic signed [TGT_W-1:0] tx_q, ty_q, tx_n, ty_n;
  logic signed [MV_W-1:0]  mvx_sum, mvy_sum;
  logic signed [RAY_W-1:0] rx_q, ry_q;
  logic signed [T_W-1:0]   t_q;
  logic [N_W-1:0]          n_q;
  logic                    blocked;
  logic                    moved_q, hit_q;
  logic [POS_W-1:0]        perp_q;
  logic [HGT_W-1:0]        height_q;

  assign mvx_sum = MV_W'(step_q * cos_q) + MV_W'(32);
  assign mvy_sum = MV_W'(step_q * sin_q) + MV_W'(32);
  assign tx_n    = signed'({2'b0, px_q}) + TGT_W'(mvx_sum >>> 6);
  assign ty_n    = signed'({2'b0, py_q}) + TGT_W'(mvy_sum >>> 6);
  assign blocked = oob_q | rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= 20'd15360;
      py_q <= 20'd15360;
    end else if (cmd_i.mv_commit && !blocked &&
                 (tx_q <= signed'({2'b0, POS_MAX})) &&
                 (ty_q <= signed'({2'b0, POS_MAX}))) begin
      px_q <= tx_q[POS_W-1:0];
      py_q <= ty_q[POS_W-1:0];
    end
  end

  // ray accumulators, also carry the move target for the probe
  always_ff @(posedge clk_i) begin
    if (cmd_i.mv_target) begin
      tx_q <= tx_n;
      ty_q <= ty_n;
      rx_q <= RAY_W'(tx_n) <<< POS_SH;
      ry_q <= RAY_W'(ty_n) <<< POS_SH;
    end else if (cmd_i.ray_init) begin
      rx_q <= {{(RAY_W-POS_W-POS_SH){1'b0}}, px_q, {POS_SH{1'b0}}};
      ry_q <= {{(RAY_W-POS_W-POS_SH){1'b0}}, py_q, {POS_SH{1'b0}}};
      t_q  <= '0;
      n_q  <= '0;
    end else if (cmd_i.step_fwd) begin
      rx_q <= rx_q + (RAY_W'(cos_q) <<< 2) + RAY_W'(cos_q);
      ry_q <= ry_q + (RAY_W'(sin_q) <<< 2) + RAY_W'(sin_q);
      t_q  <= t_q + T_W'(5);
      n_q  <= n_q + 1'b1;
    end else if (cmd_i.step_back) begin
      rx_q <= rx_q - RAY_W'(cos_q);
      ry_q <= ry_q - RAY_W'(sin_q);
      t_q  <= t_q - T_W'(1);
      n_q  <= n_q + 1'b1;
    end
  end

  // cell lookup: pixel / CELL_SIZE by reciprocal multiply
  logic [RPIX_W-1:0]  pix_x, pix_y;
  logic [PRODC_W-1:0] prod_cx, prod_cy;
  logic               oob_n;

  assign pix_x   = rx_q[RAY_W-1:FRAC_SH];
  assign pix_y   = ry_q[RAY_W-1:FRAC_SH];
  assign oob_n   = rx_q[RAY_W-1] | ry_q[RAY_W-1] |
                   (pix_x >= RPIX_W'(LIMIT)) | (pix_y >= RPIX_W'(LIMIT));
  assign prod_cx = PRODC_W'(pix_x[PIX_W-1:0]) * PRODC_W'(RECIP);
  assign prod_cy = PRODC_W'(pix_y[PIX_W-1:0]) * PRODC_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_cell) begin
      cx_q  <= prod_cx[RECIP_SH +: IDX_W];
      cy_q  <= prod_cy[RECIP_SH +: IDX_W];
      oob_q <= oob_n;
    end
  end

  // perpendicular distance and height numerator
  logic [T_W-1:0]    abs_t;
  logic [PROD_W-1:0] prod_q, prod_sh;
  logic [FOCAL_W+WHE_W-1:0] num_q;

  assign abs_t   = t_q[T_W-1] ? T_W'(-t_q) : T_W'(t_q);
  assign prod_sh = prod_q >> 6;

  always_ff @(posedge clk_i) begin
    if (cmd_i.perp_mul) begin
      prod_q <= PROD_W'(abs_t[T_W-2:0]) * PROD_W'(cc_q[CS_W-2:0]);
      num_q  <= whe_q * focal_q;
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [POS_W:0]      div_rem_q, rem2;
  logic [NUM_W-1:0]    div_quo_q;
  logic [DIVC_W-1:0]   div_cnt_q;
  logic                div_ge;

  assign rem2   = {div_rem_q[POS_W-1:0], div_quo_q[NUM_W-1]};
  assign div_ge = (rem2 >= {1'b0, perp_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      div_rem_q <= '0;
      div_quo_q <= {num_q, 8'b0};
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_rem_q <= div_ge ? rem2 - {1'b0, perp_q} : rem2;
      div_quo_q <= {div_quo_q[NUM_W-2:0], div_ge};
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  // result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      moved_q  <= 1'b0;
      hit_q    <= 1'b0;
      perp_q   <= '0;
      height_q <= '0;
    end else begin
      if (cmd_i.mv_commit && !blocked &&
          (tx_q <= signed'({2'b0, POS_MAX})) && (ty_q <= signed'({2'b0, POS_MAX}))) begin
        moved_q <= 1'b1;
      end
      if (cmd_i.perp_sat) begin
        hit_q  <= 1'b1;
        perp_q <= (64'(prod_sh) > 64'(POS_MAX)) ? POS_MAX : POS_W'(prod_sh);
      end
      if (cmd_i.h_max) begin
        height_q <= HEIGHT_MAX;
      end else if (cmd_i.h_sat) begin
        height_q <= (div_quo_q > NUM_W'(HEIGHT_MAX)) ? HEIGHT_MAX : div_quo_q[HGT_W-1:0];
      end
    end
  end

  // output word register
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= {6'b0, height_q, perp_q, hit_q, moved_q, py_q, px_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // status back to the sequencer
  assign sts_o.cor_done  = (cor_i_q == ITER_W'(CORDIC_ITERS));
  assign sts_o.blocked   = blocked;
  assign sts_o.n_max     = (32'(n_q) >= 32'(MAX_MARCH_STEPS));
  assign sts_o.perp_zero = (perp_q == '0);
  assign sts_o.div_done  = (div_cnt_q == DIVC_W'(NUM_W));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

/* rtl/grid_raycast_column_engine.sv */
// ----------------------------------------------------------------------------
// grid_raycast_column_engine
// Wall map, player move and one-column ray cast with distance and height.
//
//   channel   dir  handshake            payload
//   s_axis    in   tvalid/tready        tuser operation, tdata item fields
//   m_axis    out  tvalid/tready        tdata result fields
//   cfg       in   cfg_we_i             cfg_index_i, cfg_wdata_i
//
// One item at a time. Each march step of a cast runs a cell multiply, a map
// read and a test; the move and the cast angles run on the shared cordic,
// and the wall height comes from the bit-serial divider.
// The map has no reset and must be loaded before use.
// A finished word waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module grid_raycast_column_engine
  import rgc_pkg::*;
#(
  parameter int MAP_DIM         = MAP_DIM_DEF,
  parameter int CELL_SIZE       = CELL_SIZE_DEF,
  parameter int MAX_MARCH_STEPS = MAX_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // cell_row, cell_col, cell_is_wall, heading, step_distance, column_offset
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic [OP_W-1:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pos_x, pos_y, moved, hit, perp_distance, wall_half_height
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  rgc_cmd_t cmd;
  rgc_sts_t sts;

  rgc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rgc_dp #(
    .MAP_DIM         (MAP_DIM),
    .CELL_SIZE       (CELL_SIZE),
    .MAX_MARCH_STEPS (MAX_MARCH_STEPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

/* dv/tb_grid_raycast_column_engine.sv */
// ----------------------------------------------------------------------------
// tb_grid_raycast_column_engine
// Self-checking bench for the grid ray-cast column engine. A walled region of
// the map is loaded, then directed moves and casts at field extremes run, then
// random traffic under several register settings. A scoreboard predicts every
// result word and compares it field by field with what the engine returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_grid_raycast_column_engine;
  import rgc_pkg::*;

  localparam int N_DIM   = 64;
  localparam int N_CELL  = 40;
  localparam int N_STEPS = 1024;
  localparam int WDOG_LIMIT = 40000;
  // loaded region: rows and columns 0 .. MAP_SPAN-1, double wall on the far side
  localparam int MAP_SPAN = 12;

  typedef struct packed {
    logic [19:0] pos_x;
    logic [19:0] pos_y;
    logic        moved;
    logic        hit;
    logic [19:0] perp;
    logic [11:0] height;
  } column_res_t;

  // predicts the engine and holds the expected result words
  class column_scoreboard;
    bit          wall_map [N_DIM*N_DIM];
    logic [19:0] px, py;
    int          focal, half_ext;
    column_res_t pending_q[$];
    int          n_mismatch;

    function void init();
      px = 20'd15360;
      py = 20'd15360;
      focal = 400;
      half_ext = 20;
      n_mismatch = 0;
    endfunction

    function void set_regs(int f, int w);
      focal = f;
      half_ext = w;
    endfunction

    // cordic rotation, q2.14 cos and sin of a binary angle
    function void sin_cos(input logic [15:0] a_in, output int c, output int s);
      int atan_tab [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
      logic [15:0] a;
      bit flip;
      int x, y, z, nx, ny;
      a = a_in;
      flip = 0;
      x = 9949;
      y = 0;
      if (a >= 16'd16384 && a < 16'd49152) begin
        a = a + 16'd32768;
        flip = 1;
      end
      z = $signed(a);
      for (int i = 0; i < 14; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_tab[i];
        end else begin
          nx = x + (y >>> i); ny = y - (x >>> i); z += atan_tab[i];
        end
        x = nx; y = ny;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    // cordic vectoring, angle of a screen column
    function int col_angle(int col, int f);
      int atan_tab [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
      int x, y, z, nx, ny;
      x = f * 256;
      y = col * 256;
      z = 0;
      for (int i = 0; i < 14; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i); ny = y - (x >>> i); z += atan_tab[i];
          x = nx; y = ny;
        end else if (y < 0) begin
          nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_tab[i];
          x = nx; y = ny;
        end
      end
      return z;
    endfunction

    // outside cells count as wall
    function bit is_wall(longint x, longint y, int frac);
      longint cx, cy;
      if (x < 0 || y < 0) return 1;
      cx = (x >>> frac) / N_CELL;
      cy = (y >>> frac) / N_CELL;
      if (cx >= N_DIM || cy >= N_DIM) return 1;
      return wall_map[cy*N_DIM + cx];
    endfunction

    function void note_item(op_e op, logic [47:0] d);
      column_res_t r;
      logic [15:0] head;
      longint mv_d, tx, ty, sx, sy, t, at, p;
      int c, s, cc, nc, ang, n;
      bit ok;
      r = '0;
      head = d[28:13];
      case (op)
        OP_MAP_WRITE: wall_map[d[5:0]*N_DIM + d[11:6]] = d[12];
        OP_MOVE: begin
          mv_d = $signed(d[35:29]);
          sin_cos(head, c, s);
          tx = longint'(px) + ((mv_d * c + 32) >>> 6);
          ty = longint'(py) + ((mv_d * s + 32) >>> 6);
          if (!is_wall(tx, ty, 8) && tx <= 1048575 && ty <= 1048575) begin
            px = tx[19:0];
            py = ty[19:0];
            r.moved = 1;
          end
        end
        OP_CAST: begin
          ang = col_angle($signed(d[46:36]), focal);
          sin_cos(head + ang[15:0], c, s);
          sin_cos(ang[15:0], cc, nc);
          if (cc < 0) cc = 0;
          sx = longint'(px) * 64;
          sy = longint'(py) * 64;
          t = 0;
          n = 0;
          ok = 1;
          while (ok && !is_wall(sx + t*c, sy + t*s, 14)) begin
            if (n >= N_STEPS) ok = 0;
            else begin n++; t += 5; end
          end
          while (ok && is_wall(sx + t*c, sy + t*s, 14)) begin
            if (n >= N_STEPS) ok = 0;
            else begin n++; t -= 1; end
          end
          if (ok) begin
            at = t < 0 ? -t : t;
            p = (at * cc) >>> 6;
            if (p > 1048575) p = 1048575;
            r.hit = 1;
            r.perp = p[19:0];
            if (p == 0) r.height = 12'hFFF;
            else begin
              p = (longint'(half_ext) * focal * 256) / p;
              r.height = p > 4095 ? 12'hFFF : p[11:0];
            end
          end
        end
        default: ;
      endcase
      r.pos_x = px;
      r.pos_y = py;
      pending_q.push_back(r);
    endfunction

    function void check_word(logic [79:0] w);
      column_res_t got, exp_r;
      got.pos_x = w[19:0];
      got.pos_y = w[39:20];
      got.moved = w[40];
      got.hit = w[41];
      got.perp = w[61:42];
      got.height = w[73:62];
      if (pending_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected word %h", w);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got !== exp_r) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("mismatch: exp x=%0d y=%0d mv=%0b hit=%0b perp=%0d h=%0d",
                   exp_r.pos_x, exp_r.pos_y, exp_r.moved, exp_r.hit, exp_r.perp,
                   exp_r.height);
          $display("          got x=%0d y=%0d mv=%0b hit=%0b perp=%0d h=%0d",
                   got.pos_x, got.pos_y, got.moved, got.hit, got.perp, got.height);
        end
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic                  cfg_index_i;
  logic [CFG_W-1:0]      cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]       s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  column_scoreboard sb;
  bit quiet;
  int idle_cycles;

  grid_raycast_column_engine u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // note accepted words, check results, watch for a hang
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) sb.note_item(op_e'(s_axis_tuser), s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (idle_cycles >= WDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // result side with random stalls
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_word(op_e op, logic [5:0] row, logic [5:0] col, logic wall,
                           logic [15:0] head, logic [6:0] step_d, logic [10:0] coff);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, coff, step_d, head, wall, col, row};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // let the engine drain before touching registers
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_q.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_regs(int f, int w);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_FOCAL;
    cfg_wdata_i <= CFG_W'(f);
    @(posedge clk_i);
    cfg_index_i <= CFG_WALL_HALF;
    cfg_wdata_i <= CFG_W'(w);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_regs(f, w);
  endtask

  // map writes stay inside the walled region and keep its border
  task automatic send_random();
    int pick, r, c;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      r = $urandom_range(1, MAP_SPAN - 3);
      c = $urandom_range(1, MAP_SPAN - 3);
      send_word(OP_MAP_WRITE, 6'(r), 6'(c), $urandom_range(0, 4) == 0, 16'($urandom),
                7'($urandom), 11'($urandom));
    end else if (pick < 55)
      send_word(OP_MOVE, 6'($urandom), 6'($urandom), 1'($urandom), 16'($urandom),
                7'($urandom), 11'($urandom));
    else if (pick < 96)
      send_word(OP_CAST, 6'($urandom), 6'($urandom), 1'($urandom), 16'($urandom),
                7'($urandom),
                11'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 64) - 32));
    else
      send_word(OP_NOP, 6'($urandom), 6'($urandom), 1'($urandom), 16'($urandom),
                7'($urandom), 11'($urandom));
  endtask

  initial begin
    int pr, pc;
    logic [15:0] heads [5];
    heads = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535};
    sb = new();
    sb.init();
    idle_cycles   = 0;
    quiet         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_FOCAL;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_NOP;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // load the region: near border wall, double far border wall so that no
    // move can jump past it, sparse interior walls, start cell open
    quiet = 1'b1;
    for (int r = 0; r < MAP_SPAN; r++)
      for (int c = 0; c < MAP_SPAN; c++)
        send_word(OP_MAP_WRITE, 6'(r), 6'(c),
                  (r == 0 || c == 0 || r >= MAP_SPAN-2 || c >= MAP_SPAN-2 ||
                   ((r > 2 || c > 2) && $urandom_range(0, 9) == 0)),
                  16'd0, 7'd0, 11'd0);
    quiet = 1'b0;

    // directed: heading and column extremes, move extremes, nop
    foreach (heads[i]) begin
      send_word(OP_CAST, 6'd63, 6'd63, 1'b1, heads[i], 7'h7F, 11'h400);
      send_word(OP_CAST, 6'd0, 6'd0, 1'b0, heads[i], 7'h00, 11'h3FF);
    end
    send_word(OP_CAST, 6'd0, 6'd0, 1'b0, 16'd1000, 7'd0, 11'd0);
    send_word(OP_MOVE, 6'd0, 6'd0, 1'b0, 16'd0, 7'd63, 11'd0);
    send_word(OP_MOVE, 6'd0, 6'd0, 1'b0, 16'd16384, 7'h40, 11'd0);
    send_word(OP_MOVE, 6'd0, 6'd0, 1'b0, 16'd8192, 7'd0, 11'd0);
    send_word(OP_NOP, 6'h3F, 6'h3F, 1'b1, 16'hFFFF, 7'h7F, 11'h7FF);

    // cast from inside a wall cell, then reopen it
    drain();
    pr = (sb.py >> 8) / N_CELL;
    pc = (sb.px >> 8) / N_CELL;
    send_word(OP_MAP_WRITE, 6'(pr), 6'(pc), 1'b1, 16'd0, 7'd0, 11'd0);
    send_word(OP_CAST, 6'd0, 6'd0, 1'b0, 16'd5000, 7'd0, 11'd12);
    send_word(OP_MOVE, 6'd0, 6'd0, 1'b0, 16'd5000, 7'd10, 11'd0);
    send_word(OP_MAP_WRITE, 6'(pr), 6'(pc), 1'b0, 16'd0, 7'd0, 11'd0);

    // random phases over several register settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: ;
        1: write_regs(1, 1);
        2: write_regs(4095, 255);
        3: write_regs($urandom_range(1, 4095), $urandom_range(1, 255));
        default: write_regs($urandom_range(100, 800), $urandom_range(1, 255));
      endcase
      quiet = (ph == 3);
      for (int k = 0; k < 140; k++) send_random();
      quiet = 1'b0;
    end

    drain();
    if (sb.n_mismatch == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
